FILE: rtl/ouart_pkg.sv
package ouart_pkg;

    // Receive store geometry and bit timing
    localparam int STORE_DEPTH = 16;
    localparam int OVERSAMPLE  = 4;
    localparam int POS_W       = $clog2(STORE_DEPTH);
    localparam int PHASE_W     = $clog2(OVERSAMPLE);
    localparam int BIT_IDX_W   = 4;
    localparam int BYTE_W      = 8;

    // Frame bit positions: start is index 0, data 1..8, stop 9
    localparam logic [BIT_IDX_W-1:0] IDX_START = 4'd0;
    localparam logic [BIT_IDX_W-1:0] IDX_STOP  = 4'd9;
    localparam logic [BIT_IDX_W-1:0] IDX_DONE  = 4'd10;

    // Host action codes
    localparam int ACTION_W = 2;
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP  = 2'd2;

    // Stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // Result buffer
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

    // One result beat, tx_line in the lowest bit
    typedef struct packed {
        logic              accepted;
        logic              tx_busy;
        logic              rx_ready;
        logic [BYTE_W-1:0] rx_byte;
        logic              tx_line;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

FILE: rtl/ouart_out_fifo.sv
module ouart_out_fifo (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               push,
    input  ouart_pkg::result_t                 push_res,
    output logic [ouart_pkg::OFIFO_CNT_W-1:0]  level,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ouart_pkg::result_t                 m_res
);

    ouart_pkg::result_t                     entry_reg [ouart_pkg::OFIFO_DEPTH];
    logic [ouart_pkg::OFIFO_PTR_W-1:0]      wr_ptr_reg;
    logic [ouart_pkg::OFIFO_PTR_W-1:0]      rd_ptr_reg;
    logic [ouart_pkg::OFIFO_CNT_W-1:0]      count_reg;
    logic [ouart_pkg::OFIFO_CNT_W-1:0]      count_next;
    logic                                   pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_res   = entry_reg[rd_ptr_reg];
    assign level   = count_reg;

    // Track occupancy; the producer never pushes into a full buffer
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Hold result beats
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_res;
        end
    end

endmodule

FILE: rtl/oversampled_uart_8n1_with_rx_fifo.sv
// Channel  Dir  Beat contents (lowest bit first)
// s_       in   tuser: action[1:0]; tdata: rx_line[0], tx_data[8:1], zero pad
// m_       out  tdata: tx_line[0], rx_byte[8:1], rx_ready[9], tx_busy[10],
//                      accepted[11], zero pad
//
// One beat per clock while s_tready is high: every action updates the UART
// state in the cycle it is accepted, and the result leaves through the store
// read register, then a four-entry result buffer. Out of reset, s_tready
// drops only when that buffer plus the read stage hold four beats, so output
// stalls back up into the input. aresetn is synchronous and holds s_tready
// low while asserted; the receive store itself is not cleared.
module oversampled_uart_8n1_with_rx_fifo (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ouart_pkg::IN_TDATA_W-1:0]    s_tdata,  // rx_line, tx_data
    input  logic [ouart_pkg::ACTION_W-1:0]      s_tuser,  // action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ouart_pkg::OUT_TDATA_W-1:0]   m_tdata   // tx_line, rx_byte,
                                                          // rx_ready, tx_busy, accepted
);

    // Input fields
    logic                                   in_fire;
    logic [ouart_pkg::ACTION_W-1:0]         action;
    logic                                   rx_line;
    logic [ouart_pkg::BYTE_W-1:0]           tx_data;

    // UART state
    logic                                   tx_active_reg, tx_active_next;
    logic                                   rx_active_reg, rx_active_next;
    logic [ouart_pkg::BYTE_W-1:0]           tx_shift_reg, tx_shift_next;
    logic [ouart_pkg::BYTE_W-1:0]           rx_shift_reg, rx_shift_next;
    logic [ouart_pkg::PHASE_W-1:0]          tx_phase_reg, tx_phase_next;
    logic [ouart_pkg::PHASE_W-1:0]          rx_phase_reg, rx_phase_next;
    logic [ouart_pkg::BIT_IDX_W-1:0]        tx_bit_idx_reg, tx_bit_idx_next;
    logic [ouart_pkg::BIT_IDX_W-1:0]        rx_bit_idx_reg, rx_bit_idx_next;
    logic                                   line_out_reg, line_out_next;
    logic [ouart_pkg::POS_W-1:0]            wr_pos_reg, wr_pos_next;
    logic [ouart_pkg::POS_W-1:0]            rd_pos_reg, rd_pos_next;
    logic                                   accepted;
    logic                                   store_wr;
    logic                                   store_rd;

    // Receive store and its read register
    logic [ouart_pkg::BYTE_W-1:0]           store_mem [ouart_pkg::STORE_DEPTH];
    logic [ouart_pkg::BYTE_W-1:0]           rd_data_reg;

    // Read stage
    logic                                   p1_valid_reg;
    logic                                   p1_pop_reg;
    ouart_pkg::result_t                     p1_res_reg;
    ouart_pkg::result_t                     p1_res_next;
    ouart_pkg::result_t                     fifo_in;
    ouart_pkg::result_t                     fifo_out;
    logic [ouart_pkg::OFIFO_CNT_W-1:0]      fifo_level;
    logic [ouart_pkg::OFIFO_CNT_W-1:0]      in_flight;

    localparam logic [ouart_pkg::PHASE_W-1:0] PHASE_LAST =
        ouart_pkg::PHASE_W'(ouart_pkg::OVERSAMPLE - 1);
    localparam logic [ouart_pkg::PHASE_W-1:0] PHASE_MID =
        ouart_pkg::PHASE_W'(ouart_pkg::OVERSAMPLE / 2);
    localparam logic [ouart_pkg::POS_W-1:0] POS_LAST =
        ouart_pkg::POS_W'(ouart_pkg::STORE_DEPTH - 1);

    assign action  = s_tuser;
    assign rx_line = s_tdata[0];
    assign tx_data = s_tdata[ouart_pkg::BYTE_W:1];

    // Accept out of reset while the read stage and result buffer have room left
    assign in_flight = fifo_level + ouart_pkg::OFIFO_CNT_W'(p1_valid_reg);
    assign s_tready  = aresetn &&
                       (in_flight < ouart_pkg::OFIFO_CNT_W'(ouart_pkg::OFIFO_DEPTH));
    assign in_fire   = s_tvalid && s_tready;

    // Next state of transmitter, receiver and store pointers
    always_comb begin
        tx_active_next  = tx_active_reg;
        rx_active_next  = rx_active_reg;
        tx_shift_next   = tx_shift_reg;
        rx_shift_next   = rx_shift_reg;
        tx_phase_next   = tx_phase_reg;
        rx_phase_next   = rx_phase_reg;
        tx_bit_idx_next = tx_bit_idx_reg;
        rx_bit_idx_next = rx_bit_idx_reg;
        line_out_next   = line_out_reg;
        wr_pos_next     = wr_pos_reg;
        rd_pos_next     = rd_pos_reg;
        accepted        = 1'b0;
        store_wr        = 1'b0;
        store_rd        = 1'b0;

        unique case (action)
            ouart_pkg::ACT_TICK: begin
                accepted = 1'b1;

                // Transmitter: one bit every OVERSAMPLE ticks
                if (tx_active_reg) begin
                    if (tx_phase_reg == PHASE_LAST) begin
                        tx_phase_next = '0;
                        if (tx_bit_idx_reg == ouart_pkg::IDX_START) begin
                            line_out_next = 1'b0;
                        end else if (tx_bit_idx_reg != ouart_pkg::IDX_STOP) begin
                            line_out_next = tx_shift_reg[0];
                            tx_shift_next = {1'b0, tx_shift_reg[ouart_pkg::BYTE_W-1:1]};
                        end else begin
                            line_out_next = 1'b1;
                        end
                        if (tx_bit_idx_reg == ouart_pkg::IDX_STOP) begin
                            tx_bit_idx_next = '0;
                            tx_active_next  = 1'b0;
                        end else begin
                            tx_bit_idx_next = tx_bit_idx_reg + 1'b1;
                        end
                    end else begin
                        tx_phase_next = tx_phase_reg + 1'b1;
                    end
                end

                // Receiver: detect start, then sample near mid-bit
                if (!rx_active_reg) begin
                    if (!rx_line) begin
                        rx_phase_next   = PHASE_MID;
                        rx_active_next  = 1'b1;
                        rx_bit_idx_next = '0;
                    end
                end else if (rx_phase_reg == PHASE_LAST) begin
                    rx_phase_next = '0;
                    if (rx_bit_idx_reg == ouart_pkg::IDX_START) begin
                        if (!rx_line) begin
                            rx_bit_idx_next = rx_bit_idx_reg + 1'b1;
                        end else begin
                            rx_active_next = 1'b0;
                        end
                    end else if (rx_bit_idx_reg < ouart_pkg::IDX_STOP) begin
                        rx_shift_next   = {rx_line, rx_shift_reg[ouart_pkg::BYTE_W-1:1]};
                        rx_bit_idx_next = rx_bit_idx_reg + 1'b1;
                    end else if (rx_bit_idx_reg == ouart_pkg::IDX_STOP) begin
                        rx_bit_idx_next = ouart_pkg::IDX_DONE;
                    end else begin
                        rx_active_next = 1'b0;
                        store_wr       = 1'b1;
                        wr_pos_next    = (wr_pos_reg == POS_LAST) ? '0 : wr_pos_reg + 1'b1;
                    end
                end else begin
                    rx_phase_next = rx_phase_reg + 1'b1;
                end
            end
            ouart_pkg::ACT_SEND: begin
                if (!tx_active_reg) begin
                    tx_shift_next  = tx_data;
                    tx_active_next = 1'b1;
                    accepted       = 1'b1;
                end
            end
            ouart_pkg::ACT_POP: begin
                if (rd_pos_reg != wr_pos_reg) begin
                    store_rd    = 1'b1;
                    rd_pos_next = (rd_pos_reg == POS_LAST) ? '0 : rd_pos_reg + 1'b1;
                    accepted    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Status fields of this beat; the popped byte joins from the read register
    always_comb begin
        p1_res_next          = '0;
        p1_res_next.tx_line  = line_out_next;
        p1_res_next.rx_ready = (rd_pos_next != wr_pos_next);
        p1_res_next.tx_busy  = tx_active_next;
        p1_res_next.accepted = accepted;
    end

    // Commit state on an accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_active_reg  <= 1'b0;
            rx_active_reg  <= 1'b0;
            tx_shift_reg   <= '0;
            rx_shift_reg   <= '0;
            tx_phase_reg   <= '0;
            rx_phase_reg   <= '0;
            tx_bit_idx_reg <= '0;
            rx_bit_idx_reg <= '0;
            line_out_reg   <= 1'b1;
            wr_pos_reg     <= '0;
            rd_pos_reg     <= '0;
            p1_valid_reg   <= 1'b0;
        end else begin
            p1_valid_reg <= in_fire;
            if (in_fire) begin
                tx_active_reg  <= tx_active_next;
                rx_active_reg  <= rx_active_next;
                tx_shift_reg   <= tx_shift_next;
                rx_shift_reg   <= rx_shift_next;
                tx_phase_reg   <= tx_phase_next;
                rx_phase_reg   <= rx_phase_next;
                tx_bit_idx_reg <= tx_bit_idx_next;
                rx_bit_idx_reg <= rx_bit_idx_next;
                line_out_reg   <= line_out_next;
                wr_pos_reg     <= wr_pos_next;
                rd_pos_reg     <= rd_pos_next;
            end
        end
    end

    // Hold the status fields of the beat in the read stage
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            p1_res_reg <= p1_res_next;
            p1_pop_reg <= store_rd;
        end
    end

    // Receive store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (in_fire && store_wr) begin
            store_mem[wr_pos_reg] <= rx_shift_reg;
        end
        if (in_fire && store_rd) begin
            rd_data_reg <= store_mem[rd_pos_reg];
        end
    end

    // Merge the popped byte; zero when the beat was not a successful pop
    always_comb begin
        fifo_in         = p1_res_reg;
        fifo_in.rx_byte = p1_pop_reg ? rd_data_reg : '0;
    end

    ouart_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (p1_valid_reg),
        .push_res (fifo_in),
        .level    (fifo_level),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (fifo_out)
    );

    assign m_tdata = {(ouart_pkg::OUT_TDATA_W - ouart_pkg::RESULT_W)'(0), fifo_out};

endmodule

FILE: tb/sv/tb_oversampled_uart_8n1_with_rx_fifo.sv
module tb_oversampled_uart_8n1_with_rx_fifo;

    import ouart_pkg::*;

    // Unused action code: the block must leave its state alone
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int TICKS_EARLY = 350;
    localparam int TICKS_TOTAL = 1150;

    typedef struct {
        logic [ACTION_W-1:0] act;
        logic                line;
        logic [BYTE_W-1:0]   data;
        bit                  typed;
        result_t             want;
    } plan_row_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [ACTION_W-1:0]    s_tuser  = ACT_TICK;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // UART mirror state, advanced on every accepted input beat
    logic              tx_on    = 1'b0;
    logic              rx_on    = 1'b0;
    logic [BYTE_W-1:0] tx_sh    = '0;
    logic [BYTE_W-1:0] rx_sh    = '0;
    logic [3:0]        tx_ph    = '0;
    logic [3:0]        rx_ph    = '0;
    logic [3:0]        tx_idx   = IDX_START;
    logic [3:0]        rx_idx   = IDX_START;
    logic              line_q   = 1'b1;
    int                wr_ptr   = 0;
    int                rd_ptr   = 0;
    logic [BYTE_W-1:0] rx_mem [STORE_DEPTH];

    result_t   results_due [$];
    plan_row_t plan [$];
    int        errors     = 0;
    int        cycles     = 0;
    int        ticks_sent = 0;
    int        ready_left = 0;
    bit        gaps_on    = 1'b0;
    bit        stalls_on  = 1'b0;
    bit        pops_on    = 1'b1;

    oversampled_uart_8n1_with_rx_fifo u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_oversampled_uart_8n1_with_rx_fifo: errors");
            $finish;
        end
    end

    // Stall the result side in bursts, mostly short, while stalls are enabled
    always @(posedge aclk) begin
        if (ready_left > 0) begin
            ready_left = ready_left - 1;
        end else if (!stalls_on || $urandom_range(0, 99) < 65) begin
            m_tready <= 1'b1;
            ready_left = $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b0;
            ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                     : $urandom_range(0, 3);
        end
    end

    function automatic int next_pos(input int p);
        return (p == STORE_DEPTH - 1) ? 0 : p + 1;
    endfunction

    function automatic result_t typed_beat(input logic acc, input logic busy,
                                           input logic ready, input logic [7:0] b,
                                           input logic line);
        result_t r;
        r.accepted = acc;
        r.tx_busy  = busy;
        r.rx_ready = ready;
        r.rx_byte  = b;
        r.tx_line  = line;
        return r;
    endfunction

    // Advance the UART mirror by one action and return the beat it produces
    function automatic result_t advance_uart(input logic [ACTION_W-1:0] act,
                                             input logic line,
                                             input logic [BYTE_W-1:0] data);
        result_t r;
        r = '0;
        case (act)
            ACT_TICK: begin
                r.accepted = 1'b1;
                // transmitter: one frame bit every OVERSAMPLE ticks
                if (tx_on) begin
                    tx_ph = tx_ph + 4'd1;
                    if (tx_ph >= OVERSAMPLE) begin
                        tx_ph = '0;
                        if (tx_idx == IDX_START) begin
                            line_q = 1'b0;
                        end else if (tx_idx != IDX_STOP) begin
                            line_q = tx_sh[0];
                            tx_sh  = tx_sh >> 1;
                        end else begin
                            line_q = 1'b1;
                        end
                        tx_idx = tx_idx + 4'd1;
                        if (tx_idx > IDX_STOP) begin
                            tx_idx = IDX_START;
                            tx_on  = 1'b0;
                        end
                    end
                end
                // receiver: low line starts a frame, sample half a bit later
                if (!rx_on) begin
                    if (!line) begin
                        rx_ph  = 4'(OVERSAMPLE / 2);
                        rx_on  = 1'b1;
                        rx_idx = IDX_START;
                    end
                end else begin
                    rx_ph = rx_ph + 4'd1;
                    if (rx_ph >= OVERSAMPLE) begin
                        rx_ph = '0;
                        if (rx_idx == IDX_START) begin
                            if (!line) begin
                                rx_idx = 4'd1;
                                rx_sh  = '0;
                            end else begin
                                rx_on = 1'b0;
                            end
                        end else if (rx_idx < IDX_STOP) begin
                            if (line)
                                rx_sh[3'(rx_idx - 4'd1)] = 1'b1;
                            rx_idx = rx_idx + 4'd1;
                        end else if (rx_idx == IDX_STOP) begin
                            rx_idx = rx_idx + 4'd1;
                        end else begin
                            rx_on          = 1'b0;
                            rx_mem[wr_ptr] = rx_sh;
                            wr_ptr         = next_pos(wr_ptr);
                        end
                    end
                end
            end
            ACT_SEND: begin
                if (!tx_on) begin
                    tx_sh      = data;
                    tx_on      = 1'b1;
                    r.accepted = 1'b1;
                end
            end
            ACT_POP: begin
                if (rd_ptr != wr_ptr) begin
                    r.rx_byte  = rx_mem[rd_ptr];
                    rd_ptr     = next_pos(rd_ptr);
                    r.accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.tx_line  = line_q;
        r.rx_ready = (rd_ptr != wr_ptr);
        r.tx_busy  = tx_on;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one input beat, wait for the handshake, then log its expected result
    task automatic put_beat(input logic [ACTION_W-1:0] act, input logic line,
                            input logic [BYTE_W-1:0] data, input bit typed,
                            input result_t want);
        int gap;
        result_t model_out;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(IN_TDATA_W - BYTE_W - 1){1'b0}}, data, line};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model_out = advance_uart(act, line, data);
        results_due.push_back(typed ? want : model_out);
    endtask

    task automatic step(input logic [ACTION_W-1:0] act, input logic line,
                        input logic [BYTE_W-1:0] data);
        put_beat(act, line, data, 1'b0, '0);
    endtask

    // One baud tick, sometimes preceded by a host access
    task automatic tick(input logic line);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            step(ACT_SEND, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        else if (r < 14 && pops_on)
            step(ACT_POP, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        else if (r == 14)
            step(ACT_NONE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        step(ACT_TICK, line, 8'($urandom_range(0, 255)));
        ticks_sent++;
    endtask

    // Play one 8N1 frame on the receive line, optionally with bit-length jitter
    task automatic rx_frame(input logic [BYTE_W-1:0] b, input logic stop_lvl,
                            input bit jitter);
        logic [9:0] bits;
        int len;
        while (rx_on) tick(1'b1);
        bits = {stop_lvl, b, 1'b0};
        for (int i = 0; i < 10; i++) begin
            len = OVERSAMPLE;
            if (jitter && $urandom_range(0, 9) == 0)
                len = $urandom_range(OVERSAMPLE - 1, OVERSAMPLE + 1);
            repeat (len) tick(bits[i]);
        end
        repeat ($urandom_range(1, 4)) tick(1'b1);
    endtask

    // Mix jittered frames, some with a low stop bit, with false starts, line noise and idle stretches
    task automatic mixed_traffic(input int tick_goal);
        int r;
        while (ticks_sent < tick_goal) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                rx_frame(8'($urandom_range(0, 255)), $urandom_range(0, 9) != 0, 1'b1);
            end else if (r < 75) begin
                while (rx_on) tick(1'b1);
                tick(1'b0);
                repeat ($urandom_range(2, 4)) tick(1'b1);
            end else if (r < 88) begin
                repeat ($urandom_range(4, 24)) tick(1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 10)) tick(1'b1);
            end
            if (pops_on && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4))
                    step(ACT_POP, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[RESULT_W-1:0];
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, got %0h", $time, got);
            end else begin
                want = results_due.pop_front();
                check_field("tx_line",  BYTE_W'(want.tx_line),  BYTE_W'(got.tx_line));
                check_field("rx_byte",  want.rx_byte,           got.rx_byte);
                check_field("rx_ready", BYTE_W'(want.rx_ready), BYTE_W'(got.rx_ready));
                check_field("tx_busy",  BYTE_W'(want.tx_busy),  BYTE_W'(got.tx_busy));
                check_field("accepted", BYTE_W'(want.accepted), BYTE_W'(got.accepted));
            end
        end
    end

    initial begin
        // after reset: empty store, idle transmitter, line high
        plan.push_back('{ACT_POP,  1'b1, 8'h00, 1'b1,
                         typed_beat(1'b0, 1'b0, 1'b0, 8'h00, 1'b1)});
        plan.push_back('{ACT_NONE, 1'b1, 8'hff, 1'b1,
                         typed_beat(1'b0, 1'b0, 1'b0, 8'h00, 1'b1)});
        plan.push_back('{ACT_TICK, 1'b1, 8'h00, 1'b1,
                         typed_beat(1'b1, 1'b0, 1'b0, 8'h00, 1'b1)});
        plan.push_back('{ACT_SEND, 1'b0, 8'hff, 1'b1,
                         typed_beat(1'b1, 1'b1, 1'b0, 8'h00, 1'b1)});
        // send while busy is refused
        plan.push_back('{ACT_SEND, 1'b1, 8'h00, 1'b1,
                         typed_beat(1'b0, 1'b1, 1'b0, 8'h00, 1'b1)});
        // start bit goes out on the fourth tick
        plan.push_back('{ACT_TICK, 1'b1, 8'h00, 1'b0, '0});
        plan.push_back('{ACT_TICK, 1'b1, 8'h00, 1'b0, '0});
        plan.push_back('{ACT_TICK, 1'b1, 8'h00, 1'b0, '0});
        plan.push_back('{ACT_TICK, 1'b1, 8'h00, 1'b0, '0});
        // false start: line back high by the start-bit sample
        plan.push_back('{ACT_TICK, 1'b0, 8'h00, 1'b0, '0});
        plan.push_back('{ACT_TICK, 1'b1, 8'h00, 1'b0, '0});
        plan.push_back('{ACT_TICK, 1'b1, 8'h00, 1'b0, '0});
        plan.push_back('{ACT_POP,  1'b0, 8'hff, 1'b0, '0});
        // real start bit, then the frame runs on in the random part
        plan.push_back('{ACT_TICK, 1'b0, 8'hff, 1'b0, '0});
        plan.push_back('{ACT_TICK, 1'b0, 8'h00, 1'b0, '0});
        plan.push_back('{ACT_TICK, 1'b0, 8'h00, 1'b0, '0});
        plan.push_back('{ACT_NONE, 1'b0, 8'h00, 1'b0, '0});
        plan.push_back('{ACT_SEND, 1'b1, 8'haa, 1'b0, '0});
        plan.push_back('{ACT_TICK, 1'b1, 8'h55, 1'b0, '0});
        plan.push_back('{ACT_POP,  1'b1, 8'h00, 1'b0, '0});
        plan.push_back('{ACT_TICK, 1'b1, 8'h00, 1'b0, '0});

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i])
            put_beat(plan[i].act, plan[i].line, plan[i].data, plan[i].typed, plan[i].want);

        // random traffic with gaps and stalls on both sides
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        mixed_traffic(TICKS_EARLY);
        drain_results();

        // drain the store, then fill it past its depth with random pops, gaps and stalls off
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        pops_on   = 1'b0;
        while (rx_on) tick(1'b1);
        while (rd_ptr != wr_ptr) step(ACT_POP, 1'b0, 8'h00);
        repeat (STORE_DEPTH) rx_frame(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        repeat (2) step(ACT_POP, 1'b1, 8'h00);
        rx_frame(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        repeat (3) step(ACT_POP, 1'b0, 8'hff);

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        pops_on   = 1'b1;
        mixed_traffic(TICKS_TOTAL);

        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("tb_oversampled_uart_8n1_with_rx_fifo: clean");
        else
            $display("tb_oversampled_uart_8n1_with_rx_fifo: errors");
        $finish;
    end

endmodule
